### rtl/balance_compensator_motor_mix_macros.svh
// Assertion macros for the balance compensator
`ifndef BALANCE_COMPENSATOR_MOTOR_MIX_MACROS_SVH
`define BALANCE_COMPENSATOR_MOTOR_MIX_MACROS_SVH
// assert that antecedent implies consequent in the same cycle
`define BCM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// assert that antecedent implies consequent in the next cycle
`define BCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared constants and register indexes for the balance compensator.
// ----------------------------------------------------------------------------
package bcm_pkg;
   localparam int SAT_TRIP_TICKS_DEF = 50;
   localparam int COEF_FRAC_BITS_DEF = 16;
   localparam logic [2:0] REG_NUM0 = 3'd0;
   localparam logic [2:0] REG_NUM1 = 3'd1;
   localparam logic [2:0] REG_NUM2 = 3'd2;
   localparam logic [2:0] REG_DEN1 = 3'd3;
   localparam logic [2:0] REG_DEN2 = 3'd4;
   localparam logic [2:0] REG_TIP  = 3'd5;
   localparam logic [2:0] REG_MOUNT = 3'd6;
   localparam logic [2:0] REG_NOM  = 3'd7;
   localparam logic [13:0] NOM_RESET = 14'd7400;
   localparam logic [15:0] VB_MIN = 16'd5000;
   localparam logic [15:0] VB_MAX = 16'd9000;
   localparam logic [1:0] MODE_RUN = 2'd1;
   localparam logic [1:0] MODE_PAUSE = 2'd2;
   localparam logic [1:0] MODE_EXIT = 2'd3;
endpackage

### rtl/balance_compensator_motor_mix.sv
// ----------------------------------------------------------------------------
// balance_compensator_motor_mix
// Second-order compensator with saturation trip and differential motor mix.
// ----------------------------------------------------------------------------
// One item at a time. A control tick that runs the compensator goes through
// these stages in order:
// - the battery ratio, from a restoring divider. The divider is skipped when
//   the reading is out of range and the ratio is fixed at one.
// - the five 32-bit products, summed by a serial multiplier that retires one
//   16-bit digit of the second operand per cycle.
// - clamp, history update, mix and the output register; a saturation trip
//   goes from the history update straight to the output register.
// Items that do not run the compensator go straight to the output register.
// The result is held in an output register. The input side stays stalled
// until the result transfer.
module balance_compensator_motor_mix #(
   parameter int SAT_TRIP_TICKS = bcm_pkg::SAT_TRIP_TICKS_DEF,
   parameter int COEF_FRAC_BITS = bcm_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [1:0]         req_run_mode,
   input  logic signed [15:0] req_measured_tilt,
   input  logic signed [15:0] req_tilt_target,
   input  logic signed [15:0] req_turn_command,
   input  logic [15:0]        req_battery_millivolts,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_duty,
   output logic signed [15:0] rsp_right_duty,
   output logic               rsp_motors_on,
   output logic               rsp_armed_flag,
   output logic               rsp_tip_detected,
   output logic               rsp_saturation_trip,
   output logic signed [31:0] rsp_effort,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
`include "balance_compensator_motor_mix_macros.svh"
   localparam int CW = $clog2(SAT_TRIP_TICKS + 1);
   localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV = 3'd1, ST_MUL = 3'd2,
      ST_CLAMP = 3'd3, ST_SCALE = 3'd4, ST_MIX = 3'd5, ST_OUT = 3'd6;

   logic signed [31:0] n0_ff, n1_ff, n2_ff, d1_ff, d2_ff;
   logic [14:0] tip_ff;
   logic signed [15:0] mount_ff;
   logic [13:0] nom_ff;
   logic signed [31:0] e1_ff, e2_ff, u1_ff, u2_ff;
   logic [CW-1:0] cnt_ff;
   logic armed_ff, men_ff;
   logic [2:0] st_ff;
   logic [5:0] step_ff;
   logic signed [17:0] e0_ff;
   logic signed [15:0] turn_ff;
   logic [15:0] vb_ff;
   logic [31:0] quo_ff;
   logic [16:0] rem_ff;
   logic signed [71:0] acc_ff;
   logic signed [31:0] u_ff;
   logic [17:0] ratio_ff;
   logic sat_ff;
   logic signed [15:0] ol_ff, or_ff;
   logic om_ff, oa_ff, ot_ff, os_ff;
   logic signed [31:0] oe_ff;
   logic ov_ff;

   assign csr_ready = (st_ff == ST_IDLE) && !ov_ff;
   assign req_stall = (st_ff != ST_IDLE) || ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_left_duty = ol_ff;
   assign rsp_right_duty = or_ff;
   assign rsp_motors_on = om_ff;
   assign rsp_armed_flag = oa_ff;
   assign rsp_tip_detected = ot_ff;
   assign rsp_saturation_trip = os_ff;
   assign rsp_effort = oe_ff;

   wire req_xfer = req_valid && !req_stall;
   wire signed [16:0] tilt = 17'(req_measured_tilt) + 17'(mount_ff);
   wire [16:0] atilt = tilt[16] ? 17'(-tilt) : tilt;

   // restoring divider step: (nom<<16)/vb, one quotient bit per cycle
   wire [29:0] dividend = {nom_ff, 16'd0};
   wire [17:0] rtrial = {rem_ff, dividend[5'd29 - step_ff[4:0]]};
   wire rge = rtrial >= {2'd0, vb_ff};
   wire [17:0] rnext = rge ? rtrial - {2'd0, vb_ff} : rtrial;

   // serial MAC: step selects term (0..4) and 16-bit digit (0..1) of operand b
   logic signed [31:0] ma;
   logic signed [31:0] mb;
   logic msub;
   logic [3:0] mshift;
   always_comb begin
      ma = n0_ff; mb = 32'(e0_ff); msub = 1'b0; mshift = 4'd4;
      case (step_ff[3:1])
         3'd0: begin ma = n0_ff; mb = 32'(e0_ff); end
         3'd1: begin ma = n1_ff; mb = e1_ff; end
         3'd2: begin ma = n2_ff; mb = e2_ff; end
         3'd3: begin ma = d1_ff; mb = u1_ff; msub = 1'b1; mshift = 4'd0; end
         3'd4: begin ma = d2_ff; mb = u2_ff; msub = 1'b1; mshift = 4'd0; end
         default: begin ma = 32'sd0; mb = 32'sd0; end
      endcase
   end
   // low digit unsigned, high digit signed
   wire signed [16:0] mdig = step_ff[0] ? 17'(signed'(mb[31:16]))
                                        : signed'({1'b0, mb[15:0]});
   wire signed [48:0] mprod = ma * mdig;
   wire signed [71:0] mterm = (72'(mprod) <<< (step_ff[0] ? 5'd16 : 5'd0))
                              <<< mshift;

   wire signed [71:0] ushift = acc_ff >>> COEF_FRAC_BITS;
   wire signed [71:0] rpos = 72'(ratio_ff);
   wire signed [49:0] cprod = u_ff * signed'({1'b0, ratio_ff});
   wire signed [31:0] cval = 32'(cprod >>> 18);

   // a nominal above its usual range lets the scaled effort pass 17 bits
   logic signed [19:0] cab, sab, sadj, lsum, rsum;
   always_comb begin
      cab = cval[31] ? 20'(-cval) : 20'(cval);
      sab = turn_ff[15] ? 20'(-turn_ff) : 20'(turn_ff);
      sadj = 20'(turn_ff);
      if (cab + sab > 20'sd16384)
         sadj = (turn_ff > 16'sd0) ? 20'sd16384 - cab : cab - 20'sd16384;
      lsum = 20'(cval) + sadj;
      rsum = sadj - 20'(cval);
   end
   function automatic logic signed [15:0] sat16(input logic signed [19:0] x);
      if (x > 20'sd32767) return 16'sh7fff;
      if (x < -20'sd32768) return 16'sh8000;
      return x[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         n0_ff <= '0; n1_ff <= '0; n2_ff <= '0; d1_ff <= '0; d2_ff <= '0;
         tip_ff <= '0; mount_ff <= '0; nom_ff <= bcm_pkg::NOM_RESET;
         e1_ff <= '0; e2_ff <= '0; u1_ff <= '0; u2_ff <= '0;
         cnt_ff <= '0; armed_ff <= 1'b0; men_ff <= 1'b0;
         st_ff <= ST_IDLE; ov_ff <= 1'b0; step_ff <= '0;
      end else begin
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bcm_pkg::REG_NUM0: n0_ff <= csr_data;
               bcm_pkg::REG_NUM1: n1_ff <= csr_data;
               bcm_pkg::REG_NUM2: n2_ff <= csr_data;
               bcm_pkg::REG_DEN1: d1_ff <= csr_data;
               bcm_pkg::REG_DEN2: d2_ff <= csr_data;
               bcm_pkg::REG_TIP: tip_ff <= csr_data[14:0];
               bcm_pkg::REG_MOUNT: mount_ff <= csr_data[15:0];
               bcm_pkg::REG_NOM: nom_ff <= csr_data[13:0];
               default: ;
            endcase
         end
         case (st_ff)
            ST_IDLE: if (req_xfer) begin
               ol_ff <= '0; or_ff <= '0; ot_ff <= 1'b0; os_ff <= 1'b0;
               oe_ff <= '0;
               e0_ff <= 18'(req_tilt_target) - 18'(tilt);
               turn_ff <= req_turn_command; vb_ff <= req_battery_millivolts;
               quo_ff <= '0; rem_ff <= '0; step_ff <= '0; acc_ff <= '0;
               st_ff <= ST_OUT;
               if (req_op) begin
                  e1_ff <= '0; e2_ff <= '0; u1_ff <= '0; u2_ff <= '0;
                  armed_ff <= 1'b1; men_ff <= 1'b1;
                  om_ff <= 1'b1; oa_ff <= 1'b1;
               end else if (req_run_mode == bcm_pkg::MODE_EXIT) begin
                  men_ff <= 1'b0; om_ff <= 1'b0; oa_ff <= armed_ff;
               end else if (req_run_mode == bcm_pkg::MODE_PAUSE) begin
                  armed_ff <= 1'b0; men_ff <= 1'b0;
                  om_ff <= armed_ff ? 1'b0 : men_ff; oa_ff <= 1'b0;
               end else if (req_run_mode == bcm_pkg::MODE_RUN && armed_ff) begin
                  if (atilt > {2'd0, tip_ff}) begin
                     armed_ff <= 1'b0; men_ff <= 1'b0;
                     om_ff <= 1'b0; oa_ff <= 1'b0; ot_ff <= 1'b1;
                  end else begin
                     st_ff <= ST_DIV;
                  end
               end else begin
                  om_ff <= men_ff; oa_ff <= armed_ff;
               end
            end
            ST_DIV: begin
               if (vb_ff < bcm_pkg::VB_MIN || vb_ff > bcm_pkg::VB_MAX) begin
                  ratio_ff <= 18'd65536; step_ff <= '0; st_ff <= ST_MUL;
               end else begin
                  rem_ff <= rnext[16:0];
                  quo_ff <= {quo_ff[30:0], rge};
                  if (step_ff == 6'd29) begin
                     ratio_ff <= {quo_ff[16:0], rge};
                     step_ff <= '0; st_ff <= ST_MUL;
                  end else step_ff <= step_ff + 6'd1;
               end
            end
            ST_MUL: begin
               acc_ff <= msub ? acc_ff - mterm : acc_ff + mterm;
               if (step_ff == 6'd9) st_ff <= ST_CLAMP;
               else step_ff <= step_ff + 6'd1;
            end
            ST_CLAMP: begin
               sat_ff <= 1'b0;
               u_ff <= 32'(ushift);
               if (ushift > rpos) begin
                  u_ff <= 32'(rpos); sat_ff <= 1'b1;
               end else if (ushift < -rpos) begin
                  u_ff <= 32'(-rpos); sat_ff <= 1'b1;
               end
               st_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               e2_ff <= e1_ff; e1_ff <= 32'(e0_ff);
               u2_ff <= u1_ff; u1_ff <= u_ff; oe_ff <= u_ff;
               om_ff <= men_ff; oa_ff <= armed_ff;
               st_ff <= ST_MIX;
               if (sat_ff) begin
                  if (32'(cnt_ff) + 1 > SAT_TRIP_TICKS) begin
                     armed_ff <= 1'b0; men_ff <= 1'b0; cnt_ff <= '0;
                     om_ff <= 1'b0; oa_ff <= 1'b0; os_ff <= 1'b1;
                     st_ff <= ST_OUT;
                  end else cnt_ff <= cnt_ff + CW'(1);
               end else cnt_ff <= '0;
            end
            ST_MIX: begin
               ol_ff <= sat16(lsum); or_ff <= sat16(rsum);
               st_ff <= ST_OUT;
            end
            ST_OUT: begin
               ov_ff <= 1'b1; st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   `BCM_ASSERT_IMP(a_stall_busy, clock, reset, st_ff != ST_IDLE, req_stall, "busy not stalled")
   `BCM_ASSERT_NEXT(a_out_once, clock, reset, st_ff == ST_OUT, ov_ff, "result lost")
   `BCM_ASSERT_IMP(a_trip_dis, clock, reset, ov_ff && (ot_ff || os_ff), !oa_ff && !om_ff, "trip armed")
   `BCM_ASSERT_IMP(a_one_trip, clock, reset, ov_ff, !(ot_ff && os_ff), "two trips")
endmodule
